>>> src/rsbh_pkg.sv
// Package: widths, formats, register indexes and helpers for the segment/box hit test.
package rsbh_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int DELTA_W       = VALUE_WIDTH + 1;
    localparam int WIDE_W        = VALUE_WIDTH + 2;
    localparam int QUOT_W        = FRACTION_BITS + 1;
    localparam int T_W           = FRACTION_BITS + 2;
    localparam int DIV_STEPS     = FRACTION_BITS + 1;
    localparam int REM_W         = VALUE_WIDTH + 2;
    localparam int INDEX_W       = 3;

    localparam logic [INDEX_W-1:0] REG_BOX_LOW_X  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_BOX_LOW_Y  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BOX_LOW_Z  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_BOX_HIGH_X = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BOX_HIGH_Y = 3'd4;
    localparam logic [INDEX_W-1:0] REG_BOX_HIGH_Z = 3'd5;

    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_INSIDE = -(T_W'(1) <<< FRACTION_BITS);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] o;
        logic signed [DELTA_W-1:0]     d;
        logic signed [VALUE_WIDTH-1:0] lo;
        logic signed [VALUE_WIDTH-1:0] hi;
    } axis_t;

    typedef struct packed {
        logic       valid;
        logic       rej;
        logic [2:0] outside;
    } ctl_t;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic signed [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        if (s > $signed({VALUE_MAX[VALUE_WIDTH-1], VALUE_MAX}))
            return VALUE_MAX;
        else if (s < $signed({VALUE_MIN[VALUE_WIDTH-1], VALUE_MIN}))
            return VALUE_MIN;
        else
            return s[VALUE_WIDTH-1:0];
    endfunction

endpackage

>>> src/ray_segment_box_hit_test.sv
// Top level: pipelined ray segment versus offset axis-aligned box hit test.
//
// One word in per cycle when not stalled, one hit word out per input word, in
// order, through offset sums, slab classification, 17 restoring-division steps
// for the face distances (one quotient bit each, three axes side by side), face
// selection, the hit-point multiply and the final bounds check. A stall at the
// output freezes the whole pipeline; nothing is dropped or repeated. Write box
// registers via the cfg port only while no word is in flight; not enforced.
module ray_segment_box_hit_test (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rsbh_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [rsbh_pkg::VALUE_WIDTH-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] origin_x,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] origin_y,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] origin_z,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] end_x,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] end_y,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] end_z,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] offset_x,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] offset_y,
    input  logic signed [rsbh_pkg::VALUE_WIDTH-1:0] offset_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit
);
    import rsbh_pkg::*;

    logic signed [VALUE_WIDTH-1:0] box_lo_reg [3];
    logic signed [VALUE_WIDTH-1:0] box_hi_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                box_lo_reg[a] <= VALUE_MAX;
                box_hi_reg[a] <= VALUE_MIN;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOX_LOW_X:  box_lo_reg[0] <= cfg_data;
                REG_BOX_LOW_Y:  box_lo_reg[1] <= cfg_data;
                REG_BOX_LOW_Z:  box_lo_reg[2] <= cfg_data;
                REG_BOX_HIGH_X: box_hi_reg[0] <= cfg_data;
                REG_BOX_HIGH_Y: box_hi_reg[1] <= cfg_data;
                REG_BOX_HIGH_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    logic hit_reg;
    logic advance;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    // stage 1: offset sums and deltas
    logic signed [VALUE_WIDTH-1:0] in_o [3];
    logic signed [VALUE_WIDTH-1:0] in_e [3];
    logic signed [VALUE_WIDTH-1:0] in_off [3];
    assign in_o   = '{origin_x, origin_y, origin_z};
    assign in_e   = '{end_x, end_y, end_z};
    assign in_off = '{offset_x, offset_y, offset_z};

    logic  s1_valid_reg;
    axis_t s1_ax_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s1_ax_reg[a].o  <= in_o[a];
                s1_ax_reg[a].d  <= DELTA_W'(in_e[a]) - DELTA_W'(in_o[a]);
                s1_ax_reg[a].lo <= sat_add(box_lo_reg[a], in_off[a]);
                s1_ax_reg[a].hi <= sat_add(box_hi_reg[a], in_off[a]);
            end
        end
    end

    // stage 2: slab classification and division operands
    ctl_t                   s2_ctl_next;
    logic [VALUE_WIDTH-1:0] s2_num_next [3];
    logic [VALUE_WIDTH-1:0] s2_den_next [3];

    always_comb
    begin
        logic signed [WIDE_W-1:0] o, d, lo, hi, num;
        s2_ctl_next       = '0;
        s2_ctl_next.valid = s1_valid_reg;
        for (int a = 0; a < 3; a++)
        begin
            o   = WIDE_W'(s1_ax_reg[a].o);
            d   = WIDE_W'(s1_ax_reg[a].d);
            lo  = WIDE_W'(s1_ax_reg[a].lo);
            hi  = WIDE_W'(s1_ax_reg[a].hi);
            num = '0;
            s2_num_next[a] = '0;
            s2_den_next[a] = '0;
            if (o < lo)
            begin
                num = lo - o;
                s2_ctl_next.outside[a] = 1'b1;
                if (num > d)
                    s2_ctl_next.rej = 1'b1;
                s2_num_next[a] = num[VALUE_WIDTH-1:0];
                s2_den_next[a] = d[VALUE_WIDTH-1:0];
            end
            else if (o > hi)
            begin
                num = hi - o;
                s2_ctl_next.outside[a] = 1'b1;
                if (num < d)
                    s2_ctl_next.rej = 1'b1;
                num = -num;
                d   = -d;
                s2_num_next[a] = num[VALUE_WIDTH-1:0];
                s2_den_next[a] = d[VALUE_WIDTH-1:0];
            end
        end
    end

    ctl_t                   s2_ctl_reg;
    axis_t                  s2_ax_reg  [3];
    logic [VALUE_WIDTH-1:0] s2_num_reg [3];
    logic [VALUE_WIDTH-1:0] s2_den_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_ctl_reg <= '0;
        else if (advance)
            s2_ctl_reg <= s2_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_ax_reg  <= s1_ax_reg;
            s2_num_reg <= s2_num_next;
            s2_den_reg <= s2_den_next;
        end
    end

    // division: one quotient bit per stage, most significant first
    ctl_t                   dv_ctl_reg [DIV_STEPS];
    axis_t                  dv_ax_reg  [DIV_STEPS][3];
    logic [REM_W-1:0]       dv_rem_reg [DIV_STEPS][3];
    logic [QUOT_W-1:0]      dv_q_reg   [DIV_STEPS][3];
    logic [VALUE_WIDTH-1:0] dv_den_reg [DIV_STEPS][3];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        ctl_t                   ctl_prev;
        axis_t                  ax_prev  [3];
        logic [REM_W-1:0]       r_shift  [3];
        logic [QUOT_W-1:0]      q_prev   [3];
        logic [VALUE_WIDTH-1:0] den_prev [3];
        logic [REM_W-1:0]       rem_next [3];
        logic [QUOT_W-1:0]      q_next   [3];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                ctl_prev = s2_ctl_reg;
                ax_prev  = s2_ax_reg;
                for (int a = 0; a < 3; a++)
                begin
                    r_shift[a]  = REM_W'(s2_num_reg[a]);
                    q_prev[a]   = '0;
                    den_prev[a] = s2_den_reg[a];
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                ctl_prev = dv_ctl_reg[k-1];
                ax_prev  = dv_ax_reg[k-1];
                for (int a = 0; a < 3; a++)
                begin
                    r_shift[a]  = dv_rem_reg[k-1][a] << 1;
                    q_prev[a]   = dv_q_reg[k-1][a];
                    den_prev[a] = dv_den_reg[k-1][a];
                end
            end
        end

        always_comb
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (r_shift[a] >= REM_W'(den_prev[a]))
                begin
                    rem_next[a] = r_shift[a] - REM_W'(den_prev[a]);
                    q_next[a]   = {q_prev[a][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[a] = r_shift[a];
                    q_next[a]   = {q_prev[a][QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_ctl_reg[k] <= '0;
            else if (advance)
                dv_ctl_reg[k] <= ctl_prev;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_ax_reg[k]  <= ax_prev;
                dv_rem_reg[k] <= rem_next;
                dv_q_reg[k]   <= q_next;
                dv_den_reg[k] <= den_prev;
            end
        end
    end

    // face selection
    ctl_t                  dl_ctl;
    logic signed [T_W-1:0] t_val [3];
    logic [1:0]            which;
    logic [QUOT_W-1:0]     t_sel;
    logic                  all_inside;

    assign dl_ctl     = dv_ctl_reg[DIV_STEPS-1];
    assign all_inside = (dl_ctl.outside == 3'b000);

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            t_val[a] = dl_ctl.outside[a] ? $signed({1'b0, dv_q_reg[DIV_STEPS-1][a]})
                                         : T_INSIDE;
        which = 2'd0;
        if (t_val[1] > t_val[0])
            which = 2'd1;
        if (t_val[2] > t_val[which])
            which = 2'd2;
        t_sel = dv_q_reg[DIV_STEPS-1][which];
    end

    logic              sl_valid_reg, sl_rej_reg, sl_inside_reg;
    logic [QUOT_W-1:0] sl_t_reg;
    axis_t             sl_u_reg, sl_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sl_valid_reg <= 1'b0;
        else if (advance)
            sl_valid_reg <= dl_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sl_rej_reg    <= dl_ctl.rej;
            sl_inside_reg <= all_inside;
            sl_t_reg      <= t_sel;
            sl_u_reg      <= dv_ax_reg[DIV_STEPS-1][(which == 2'd0) ? 2'd1 : 2'd0];
            sl_v_reg      <= dv_ax_reg[DIV_STEPS-1][(which == 2'd2) ? 2'd1 : 2'd2];
        end
    end

    // hit-point offsets along the segment
    logic [VALUE_WIDTH+QUOT_W-1:0] prod_u, prod_v;
    logic [DELTA_W-1:0]            abs_u, abs_v;

    assign abs_u  = sl_u_reg.d[DELTA_W-1] ? DELTA_W'(-sl_u_reg.d) : DELTA_W'(sl_u_reg.d);
    assign abs_v  = sl_v_reg.d[DELTA_W-1] ? DELTA_W'(-sl_v_reg.d) : DELTA_W'(sl_v_reg.d);
    assign prod_u = abs_u[VALUE_WIDTH-1:0] * sl_t_reg;
    assign prod_v = abs_v[VALUE_WIDTH-1:0] * sl_t_reg;

    logic                   ml_valid_reg, ml_rej_reg, ml_inside_reg;
    axis_t                  ml_u_reg, ml_v_reg;
    logic [VALUE_WIDTH-1:0] ml_mag_u_reg, ml_mag_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ml_valid_reg <= 1'b0;
        else if (advance)
            ml_valid_reg <= sl_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ml_rej_reg    <= sl_rej_reg;
            ml_inside_reg <= sl_inside_reg;
            ml_u_reg      <= sl_u_reg;
            ml_v_reg      <= sl_v_reg;
            ml_mag_u_reg  <= prod_u[FRACTION_BITS +: VALUE_WIDTH];
            ml_mag_v_reg  <= prod_v[FRACTION_BITS +: VALUE_WIDTH];
        end
    end

    // bounds check on the two other axes
    logic signed [WIDE_W-1:0] pu, pv;
    logic                     ok, hit_next;

    assign pu = ml_u_reg.d[DELTA_W-1] ? WIDE_W'(ml_u_reg.o) - WIDE_W'({1'b0, ml_mag_u_reg})
                                      : WIDE_W'(ml_u_reg.o) + WIDE_W'({1'b0, ml_mag_u_reg});
    assign pv = ml_v_reg.d[DELTA_W-1] ? WIDE_W'(ml_v_reg.o) - WIDE_W'({1'b0, ml_mag_v_reg})
                                      : WIDE_W'(ml_v_reg.o) + WIDE_W'({1'b0, ml_mag_v_reg});
    assign ok = !(pu < WIDE_W'(ml_u_reg.lo) || pu > WIDE_W'(ml_u_reg.hi)) &&
                !(pv < WIDE_W'(ml_v_reg.lo) || pv > WIDE_W'(ml_v_reg.hi));
    assign hit_next = ml_rej_reg ? 1'b0 : (ml_inside_reg ? 1'b1 : ok);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= ml_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            hit_reg <= hit_next;
    end

endmodule
